// File: hw/rtl/cmms_pkg.sv
// Package for the crop / mirror / mean-subtract / scale pixel block.
// Sizes, register map, configuration and position types, dimension clamp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cmms_pkg;

	// Image geometry and channel count
	localparam int MAX_DIM  = 1024;
	localparam int CHANNELS = 3;
	localparam int DIM_W    = $clog2(MAX_DIM);   // row / column counter width
	localparam int SIZE_W   = DIM_W + 1;         // holds sizes up to MAX_DIM
	localparam int CH_W     = 2;
	localparam int PLANE_W  = CH_W + SIZE_W;     // channel * out_rows

	// Field widths
	localparam int PIX_W   = 8;
	localparam int MEAN_W  = 16;
	localparam int SCALE_W = 18;
	localparam int DIFF_W  = PIX_W + 9;          // signed pixel*256 - mean
	localparam int PROD_W  = DIFF_W + SCALE_W + 1;
	localparam int VALUE_W = 27;
	localparam int IDX_W   = 22;
	localparam int OFS_W   = 10;                 // each crop offset field
	localparam int MEANS_W = 48;

	// Configuration port
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// Register indexes (byte address = 8 * index)
	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH   = 3'd0,
		REG_IMAGE_HEIGHT  = 3'd1,
		REG_CROP_WIDTH    = 3'd2,
		REG_CROP_HEIGHT   = 3'd3,
		REG_CROP_OFFSETS  = 3'd4,
		REG_MIRROR        = 3'd5,
		REG_SCALE         = 3'd6,
		REG_CHANNEL_MEANS = 3'd7
	} reg_idx_t;

	// Decoded configuration handed to the datapath
	typedef struct packed {
		logic [SIZE_W-1:0]  w_sat;
		logic [SIZE_W-1:0]  h_sat;
		logic [SIZE_W-1:0]  out_cols;
		logic [SIZE_W-1:0]  out_rows;
		logic [DIM_W-1:0]   top;
		logic [DIM_W-1:0]   left;
		logic               mirror;
		logic [SCALE_W-1:0] scale;
		logic [MEANS_W-1:0] means;
	} cfg_t;

	// Position of one byte in the incoming image
	typedef struct packed {
		logic [DIM_W-1:0] row;
		logic [DIM_W-1:0] col;
		logic [CH_W-1:0]  ch;
	} pos_t;

	// Clamp an image dimension to 1..MAX_DIM
	function automatic logic [SIZE_W-1:0] sat_dim(input logic [10:0] v);
		logic [SIZE_W-1:0] r;
		if (v == 11'd0) begin
			r = SIZE_W'(1);
		end else if (32'(v) > MAX_DIM) begin
			r = SIZE_W'(MAX_DIM);
		end else begin
			r = SIZE_W'(v);
		end
		return r;
	endfunction

	// Clamp a crop size to MAX_DIM
	function automatic logic [SIZE_W-1:0] sat_crop(input logic [10:0] v);
		logic [SIZE_W-1:0] r;
		if (32'(v) > MAX_DIM) begin
			r = SIZE_W'(MAX_DIM);
		end else begin
			r = SIZE_W'(v);
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/cmms_regs.sv
// Configuration register file with APB-style access.
// Decodes the registers into cfg_t for the datapath. Depends on cmms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmms_regs import cmms_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [10:0]        image_width_q;
	logic [10:0]        image_height_q;
	logic [10:0]        crop_width_q;
	logic [10:0]        crop_height_q;
	logic [19:0]        crop_offsets_q;
	logic               mirror_q;
	logic [SCALE_W-1:0] scale_q;
	logic [MEANS_W-1:0] means_q;
	reg_idx_t           idx;
	logic               wr_en;
	logic               crop_on;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign wr_en  = psel && penable && pwrite && pready;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= 11'd1024;
			image_height_q <= 11'd1024;
			crop_width_q   <= '0;
			crop_height_q  <= '0;
			crop_offsets_q <= '0;
			mirror_q       <= 1'b0;
			scale_q        <= SCALE_W'(65536);
			means_q        <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_IMAGE_WIDTH:   image_width_q  <= pwdata[10:0];
				REG_IMAGE_HEIGHT:  image_height_q <= pwdata[10:0];
				REG_CROP_WIDTH:    crop_width_q   <= pwdata[10:0];
				REG_CROP_HEIGHT:   crop_height_q  <= pwdata[10:0];
				REG_CROP_OFFSETS:  crop_offsets_q <= pwdata[19:0];
				REG_MIRROR:        mirror_q       <= pwdata[0];
				REG_SCALE:         scale_q        <= pwdata[SCALE_W-1:0];
				REG_CHANNEL_MEANS: means_q        <= pwdata[MEANS_W-1:0];
			endcase
		end
	end

	// Read mux
	always_comb begin
		unique case (idx)
			REG_IMAGE_WIDTH:   prdata = DATA_W'(image_width_q);
			REG_IMAGE_HEIGHT:  prdata = DATA_W'(image_height_q);
			REG_CROP_WIDTH:    prdata = DATA_W'(crop_width_q);
			REG_CROP_HEIGHT:   prdata = DATA_W'(crop_height_q);
			REG_CROP_OFFSETS:  prdata = DATA_W'(crop_offsets_q);
			REG_MIRROR:        prdata = DATA_W'(mirror_q);
			REG_SCALE:         prdata = DATA_W'(scale_q);
			REG_CHANNEL_MEANS: prdata = DATA_W'(means_q);
		endcase
	end

	// Decoded window: crop only when both sizes are nonzero
	assign crop_on = (crop_width_q != 11'd0) && (crop_height_q != 11'd0);

	always_comb begin
		cfg.w_sat  = sat_dim(image_width_q);
		cfg.h_sat  = sat_dim(image_height_q);
		cfg.mirror = mirror_q;
		cfg.scale  = scale_q;
		cfg.means  = means_q;
		if (crop_on) begin
			cfg.out_cols = sat_crop(crop_width_q);
			cfg.out_rows = sat_crop(crop_height_q);
			cfg.top      = DIM_W'(crop_offsets_q[2*OFS_W-1:OFS_W]);
			cfg.left     = DIM_W'(crop_offsets_q[OFS_W-1:0]);
		end else begin
			cfg.out_cols = cfg.w_sat;
			cfg.out_rows = cfg.h_sat;
			cfg.top      = '0;
			cfg.left     = '0;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/cmms_seq.sv
// Row / column / channel position counters for the incoming byte stream.
// Start flag forces the first position. Depends on cmms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmms_seq import cmms_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              start_req,
	input  wire logic [SIZE_W-1:0] w_sat,
	input  wire logic [SIZE_W-1:0] h_sat,
	output pos_t                   cur_pos
);

	logic [DIM_W-1:0] row_q;
	logic [DIM_W-1:0] col_q;
	logic [CH_W-1:0]  ch_q;
	pos_t             nxt_pos;

	// Position of the byte now at the input
	always_comb begin
		if (start_req) begin
			cur_pos = '0;
		end else begin
			cur_pos.row = row_q;
			cur_pos.col = col_q;
			cur_pos.ch  = ch_q;
		end
	end

	// Advance channel, then column, then row, wrapping at the image end
	always_comb begin
		nxt_pos = '0;
		if (32'(cur_pos.ch) + 1 < CHANNELS) begin
			nxt_pos     = cur_pos;
			nxt_pos.ch  = cur_pos.ch + CH_W'(1);
		end else if ({1'b0, cur_pos.col} + SIZE_W'(1) < w_sat) begin
			nxt_pos.row = cur_pos.row;
			nxt_pos.col = cur_pos.col + DIM_W'(1);
		end else if ({1'b0, cur_pos.row} + SIZE_W'(1) < h_sat) begin
			nxt_pos.row = cur_pos.row + DIM_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			ch_q  <= '0;
		end else if (accept) begin
			row_q <= nxt_pos.row;
			col_q <= nxt_pos.col;
			ch_q  <= nxt_pos.ch;
		end
	end

	a_ch_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ch_q) < CHANNELS)
		else $error("channel counter out of range");

endmodule

`default_nettype wire

// File: hw/rtl/cmms_proc.sv
// Two-register datapath: input register, window / scale / index logic,
// result register with stall handling. Depends on cmms_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cmms_proc import cmms_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cfg_t               cfg,
	input  wire logic               pix_valid,
	output logic                    pix_stall,
	input  wire logic [PIX_W-1:0]   pixel,
	input  wire pos_t               cur_pos,
	output logic                    accept,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic signed [VALUE_W-1:0] value,
	output logic [IDX_W-1:0]        dest_index,
	output logic [CH_W-1:0]         channel,
	output logic                    last
);

	// Input stage
	logic               s1_valid;
	logic [PIX_W-1:0]   pixel_s1;
	pos_t               pos_s1;
	logic [PLANE_W-1:0] plane_s1;
	logic [PLANE_W-1:0] plane_in;

	// Stage logic
	logic [SIZE_W-1:0]        r_full;
	logic [SIZE_W-1:0]        c_full;
	logic [SIZE_W-1:0]        c_out;
	logic                     keep;
	logic                     last_c;
	logic [MEAN_W-1:0]        mean;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic [PLANE_W:0]         row_lin;
	logic [PLANE_W+SIZE_W+1:0] idx_full;
	logic                     s2_free;
	logic                     s1_adv;

	// Flow control: a dropped byte never waits on the output
	assign s2_free   = !res_valid || !res_stall;
	assign s1_adv    = !s1_valid || !keep || s2_free;
	assign pix_stall = !s1_adv;
	assign accept    = pix_valid && s1_adv;

	// Plane base offset: channel times output rows
	assign plane_in = PLANE_W'(cur_pos.ch) * PLANE_W'(cfg.out_rows);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s1_adv) begin
			s1_valid <= pix_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= pixel;
			pos_s1   <= cur_pos;
			plane_s1 <= plane_in;
		end
	end

	// Crop window test and window-relative position
	always_comb begin
		r_full = {1'b0, pos_s1.row} - {1'b0, cfg.top};
		c_full = {1'b0, pos_s1.col} - {1'b0, cfg.left};
		keep   = (pos_s1.row >= cfg.top) && (r_full < cfg.out_rows) &&
		         (pos_s1.col >= cfg.left) && (c_full < cfg.out_cols);
		last_c = (r_full == cfg.out_rows - SIZE_W'(1)) &&
		         (c_full == cfg.out_cols - SIZE_W'(1)) &&
		         (32'(pos_s1.ch) == CHANNELS - 1);
		c_out  = cfg.mirror ? (cfg.out_cols - SIZE_W'(1) - c_full) : c_full;
	end

	// Per-channel mean; a fourth channel has none
	always_comb begin
		unique case (pos_s1.ch)
			2'd0:    mean = cfg.means[MEAN_W-1:0];
			2'd1:    mean = cfg.means[2*MEAN_W-1:MEAN_W];
			2'd2:    mean = cfg.means[3*MEAN_W-1:2*MEAN_W];
			default: mean = '0;
		endcase
	end

	// Mean subtract and scale; drop 8 fraction bits with floor
	assign diff = $signed({1'b0, pixel_s1, 8'b0}) - $signed({1'b0, mean});
	assign prod = diff * $signed({1'b0, cfg.scale});

	// Planar destination index
	assign row_lin  = {1'b0, plane_s1} + (PLANE_W+1)'(r_full[DIM_W-1:0]);
	assign idx_full = (PLANE_W+SIZE_W+2)'(row_lin) * (PLANE_W+SIZE_W+2)'(cfg.out_cols) +
	                  (PLANE_W+SIZE_W+2)'(c_out);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (s2_free) begin
			res_valid <= s1_valid && keep;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_valid && keep) begin
			value      <= prod[VALUE_W+7:8];
			dest_index <= idx_full[IDX_W-1:0];
			channel    <= pos_s1.ch;
			last       <= last_c;
		end
	end

	a_last_channel: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && last |-> 32'(channel) == CHANNELS - 1)
		else $error("last flag on a channel other than the final one");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall |-> s1_valid && keep && res_valid && res_stall)
		else $error("input stalled without a blocked kept byte");

	a_kept_moves: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && keep && s2_free |=> res_valid)
		else $error("kept byte lost between stages");

endmodule

`default_nettype wire

// File: hw/rtl/crop_mirror_mean_scale_pixel.sv
// Top level of the crop / mirror / mean-subtract / scale pixel block.
// Instantiates cmms_regs, cmms_seq and cmms_proc; depends on cmms_pkg.
//
//   channel   handshake               payload
//   input     pix_valid / pix_stall   pixel, start_req
//   result    res_valid / res_stall   value, dest_index, channel, last
//   config    psel/penable/pwrite     paddr, pwdata, prdata (pready tied high)
//
// One byte is accepted per cycle while pix_stall is low. The accepting edge loads the
// input register; a kept byte then moves into the result register, which drives the
// result port, once that register is free (res_valid low or res_stall low).
// Bytes outside the crop window give no result and never wait on res_stall.
// A stalled result blocks input only when the input register holds a kept byte.
// Reset clears the position counters and valid flags and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module crop_mirror_mean_scale_pixel import cmms_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pix_valid,
	output logic                      pix_stall,
	input  wire logic [PIX_W-1:0]     pixel,
	input  wire logic                 start_req,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic signed [VALUE_W-1:0] value,
	output logic [IDX_W-1:0]          dest_index,
	output logic [CH_W-1:0]           channel,
	output logic                      last,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [ADDR_W-1:0]    paddr,
	input  wire logic [DATA_W-1:0]    pwdata,
	output logic      [DATA_W-1:0]    prdata,
	output logic                      pready
);

	cfg_t cfg;
	pos_t cur_pos;
	logic accept;

	cmms_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cmms_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.start_req (start_req),
		.w_sat     (cfg.w_sat),
		.h_sat     (cfg.h_sat),
		.cur_pos   (cur_pos)
	);

	cmms_proc u_proc (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pix_valid  (pix_valid),
		.pix_stall  (pix_stall),
		.pixel      (pixel),
		.cur_pos    (cur_pos),
		.accept     (accept),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.value      (value),
		.dest_index (dest_index),
		.channel    (channel),
		.last       (last)
	);

endmodule

`default_nettype wire

// File: dv/crop_mirror_mean_scale_pixel_tb.sv
// Testbench for crop_mirror_mean_scale_pixel: random byte streams, APB register setup
// and a scoreboard that predicts every kept byte and checks each result in order.
// Depends on cmms_pkg and the block's RTL.
`timescale 1ns / 1ps

// One expected result of a kept byte
typedef struct {
	logic [26:0] value;
	logic [21:0] dest;
	logic [1:0]  chan;
	logic        is_last;
} scaled_pixel_t;

// Register copies, byte position counters and the queue of expected results
class scaled_pixel_board;
	logic [10:0] img_w, img_h, crop_w, crop_h;
	logic [19:0] crop_ofs;
	logic        mirror_on;
	logic [17:0] scale_val;
	logic [47:0] means;
	int unsigned row_pos, col_pos, ch_pos;
	scaled_pixel_t pending_pixels[$];
	int unsigned bytes_taken, results_checked, errors;

	function new();
		img_w = 11'd1024;
		img_h = 11'd1024;
		crop_w = '0;
		crop_h = '0;
		crop_ofs = '0;
		mirror_on = 1'b0;
		scale_val = 18'd65536;
		means = '0;
		row_pos = 0;
		col_pos = 0;
		ch_pos = 0;
		bytes_taken = 0;
		results_checked = 0;
		errors = 0;
	endfunction

	function void set_reg(cmms_pkg::reg_idx_t idx, logic [63:0] data);
		case (idx)
			cmms_pkg::REG_IMAGE_WIDTH:   img_w = data[10:0];
			cmms_pkg::REG_IMAGE_HEIGHT:  img_h = data[10:0];
			cmms_pkg::REG_CROP_WIDTH:    crop_w = data[10:0];
			cmms_pkg::REG_CROP_HEIGHT:   crop_h = data[10:0];
			cmms_pkg::REG_CROP_OFFSETS:  crop_ofs = data[19:0];
			cmms_pkg::REG_MIRROR:        mirror_on = data[0];
			cmms_pkg::REG_SCALE:         scale_val = data[17:0];
			cmms_pkg::REG_CHANNEL_MEANS: means = data[47:0];
			default: ;
		endcase
	endfunction

	// image size as the block uses it: 1..MAX_DIM
	function int unsigned fit_dim(logic [10:0] v);
		if (v == 0) return 1;
		if (v > cmms_pkg::MAX_DIM) return cmms_pkg::MAX_DIM;
		return v;
	endfunction

	function int unsigned pending();
		return pending_pixels.size();
	endfunction

	// Accepted input transaction: advance the position, queue a result if kept
	function void note_byte(logic [7:0] pix, logic sof);
		int unsigned w, h, rows, cols, top, left, row, col, ch, r, c, mean;
		longint diff, prod;
		scaled_pixel_t e;
		bytes_taken++;
		w = fit_dim(img_w);
		h = fit_dim(img_h);
		if (sof) begin
			row_pos = 0;
			col_pos = 0;
			ch_pos = 0;
		end
		rows = h;
		cols = w;
		top = 0;
		left = 0;
		// crop only when both window sizes are nonzero
		if (crop_w != 0 && crop_h != 0) begin
			cols = (crop_w > cmms_pkg::MAX_DIM) ? cmms_pkg::MAX_DIM : crop_w;
			rows = (crop_h > cmms_pkg::MAX_DIM) ? cmms_pkg::MAX_DIM : crop_h;
			top = crop_ofs[19:10];
			left = crop_ofs[9:0];
		end
		row = row_pos;
		col = col_pos;
		ch = ch_pos;
		// step to the next byte; wraps to a new image after the last one
		if (ch_pos + 1 < cmms_pkg::CHANNELS) begin
			ch_pos++;
		end else begin
			ch_pos = 0;
			if (col_pos + 1 < w) begin
				col_pos++;
			end else begin
				col_pos = 0;
				row_pos = (row_pos + 1 < h) ? row_pos + 1 : 0;
			end
		end
		// dropped outside the window
		if (row < top || row - top >= rows || col < left || col - left >= cols) return;
		r = row - top;
		c = col - left;
		e.is_last = (r == rows - 1) && (c == cols - 1) && (ch == cmms_pkg::CHANNELS - 1);
		if (mirror_on) c = cols - 1 - c;
		mean = (ch < 3) ? ((means >> (16 * ch)) & 48'hFFFF) : 0;
		// 8.8 difference times 2.16 scale; floor of the 24 fraction bits down to 16
		diff = longint'(pix) * 256 - longint'(mean);
		prod = diff * longint'(scale_val);
		e.value = 27'(prod >>> 8);
		e.dest = 22'((ch * rows + r) * cols + c);
		e.chan = 2'(ch);
		pending_pixels.insert(pending_pixels.size(), e);
	endfunction

	// Accepted result transaction against the oldest expectation
	function void check_output(logic [26:0] v, logic [21:0] d, logic [1:0] chn, logic lst);
		scaled_pixel_t e;
		if (pending_pixels.size() == 0) begin
			$display("%0t: unexpected result, value %0d dest_index %0d channel %0d",
				$time, $signed(v), d, chn);
			errors++;
			return;
		end
		e = pending_pixels.pop_front();
		results_checked++;
		if (v !== e.value) begin
			$display("%0t: value mismatch, expected %0d, actual %0d",
				$time, $signed(e.value), $signed(v));
			errors++;
		end
		if (d !== e.dest) begin
			$display("%0t: dest_index mismatch, expected %0d, actual %0d", $time, e.dest, d);
			errors++;
		end
		if (chn !== e.chan) begin
			$display("%0t: channel mismatch, expected %0d, actual %0d", $time, e.chan, chn);
			errors++;
		end
		if (lst !== e.is_last) begin
			$display("%0t: last mismatch, expected %0b, actual %0b", $time, e.is_last, lst);
			errors++;
		end
	endfunction
endclass

module crop_mirror_mean_scale_pixel_tb;
	import cmms_pkg::*;

	localparam int RAND_ITEMS    = 1250;
	localparam int TAIL_ITEMS    = 150;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_LIMIT    = 4000;
	localparam int SETTLE_CYCLES = 6;
	localparam int IMAGE_CAP     = 240;

	logic                      clk;
	logic                      arst_n;
	logic                      pix_valid;
	logic                      pix_stall;
	logic [PIX_W-1:0]          pixel;
	logic                      start_req;
	logic                      res_valid;
	logic                      res_stall;
	logic signed [VALUE_W-1:0] value;
	logic [IDX_W-1:0]          dest_index;
	logic [CH_W-1:0]           channel;
	logic                      last;
	logic                      psel;
	logic                      penable;
	logic                      pwrite;
	logic [ADDR_W-1:0]         paddr;
	logic [DATA_W-1:0]         pwdata;
	logic [DATA_W-1:0]         prdata;
	logic                      pready;

	bit                calm;
	bit                hold_req;
	int unsigned       rand_bytes;
	int unsigned       phase_count;
	scaled_pixel_board board;

	crop_mirror_mean_scale_pixel u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix_valid(pix_valid),
		.pix_stall(pix_stall),
		.pixel(pixel),
		.start_req(start_req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.value(value),
		.dest_index(dest_index),
		.channel(channel),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Monitor: both channels sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) board.check_output(value, dest_index, channel, last);
			if (pix_valid && !pix_stall) board.note_byte(pixel, start_req);
		end
	end

	// Result side: random stall bursts, and one long hold-off on request
	initial begin
		int unsigned burst;
		res_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (!calm && $urandom_range(0, 14) == 0) begin
				burst = $urandom_range(1, 19);
				res_stall <= 1'b1;
				repeat (burst) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long
	initial begin
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && !pix_stall) || (res_valid && !res_stall)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("%0t: no transaction for %0d cycles, run stopped", $time, IDLE_LIMIT);
		$display("*** FAILED ***");
		$finish;
	end

	// APB write: setup cycle, then access until pready
	task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		board.set_reg(idx, data);
		@(posedge clk);
	endtask

	task automatic load_config(input logic [10:0] img_cols, input logic [10:0] img_rows,
			input logic [10:0] win_cols, input logic [10:0] win_rows,
			input logic [19:0] win_ofs, input logic mir, input logic [17:0] mult,
			input logic [47:0] mn);
		write_reg(REG_IMAGE_WIDTH, DATA_W'(img_cols));
		write_reg(REG_IMAGE_HEIGHT, DATA_W'(img_rows));
		write_reg(REG_CROP_WIDTH, DATA_W'(win_cols));
		write_reg(REG_CROP_HEIGHT, DATA_W'(win_rows));
		write_reg(REG_CROP_OFFSETS, DATA_W'(win_ofs));
		write_reg(REG_MIRROR, DATA_W'(mir));
		write_reg(REG_SCALE, DATA_W'(mult));
		write_reg(REG_CHANNEL_MEANS, DATA_W'(mn));
	endtask

	// Stop input, wait for every expected result, then cover the pipeline latency
	task automatic drain();
		pix_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One input transaction, with an occasional idle burst ahead of it
	task automatic send_byte(input logic [PIX_W-1:0] pix, input logic sof);
		int unsigned gap;
		if (!calm && $urandom_range(0, 11) == 0) begin
			gap = $urandom_range(1, 19);
			pix_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_valid <= 1'b1;
		pixel <= pix;
		start_req <= sof;
		@(posedge clk);
		while (pix_stall) @(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom);
		endcase
	endfunction

	// Stream of random bytes; noisy streams raise start_req at random points too
	task automatic send_image(input int unsigned nbytes, input bit with_start, input bit noisy);
		for (int unsigned i = 0; i < nbytes; i++)
			send_byte(rand_pixel(), (i == 0 && with_start) || (noisy && $urandom_range(0, 49) == 0));
	endtask

	function automatic logic [10:0] pick_dim();
		case ($urandom_range(0, 19))
			0: return 11'd0;
			1: return 11'($urandom);
			2: return 11'd1024;
			default: return 11'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [17:0] pick_scale();
		case ($urandom_range(0, 5))
			0: return 18'd0;
			1: return 18'h3FFFF;
			2: return 18'd65536;
			default: return 18'($urandom);
		endcase
	endfunction

	function automatic logic [47:0] pick_means();
		case ($urandom_range(0, 5))
			0: return 48'd0;
			1: return 48'hFFFF_FFFF_FFFF;
			default: return 48'({$urandom, $urandom});
		endcase
	endfunction

	// Random settings, then one to three images, some cut short or without start
	task automatic random_phase();
		logic [10:0] w_reg, h_reg, cw, chh;
		logic [9:0]  top, left;
		int unsigned w_fit, h_fit, full, n, images;
		w_reg = pick_dim();
		h_reg = pick_dim();
		w_fit = board.fit_dim(w_reg);
		h_fit = board.fit_dim(h_reg);
		top = '0;
		left = '0;
		case ($urandom_range(0, 5))
			0: begin
				cw = 11'd0;
				chh = 11'($urandom_range(0, 8));
			end
			1: begin
				cw = 11'($urandom_range(1, 8));
				chh = 11'd0;
			end
			2: begin
				cw = 11'($urandom);
				chh = 11'($urandom);
				top = 10'($urandom);
				left = 10'($urandom);
			end
			3: begin
				// window may run past the image edge
				cw = 11'($urandom_range(1, w_fit + 2));
				chh = 11'($urandom_range(1, h_fit + 2));
				top = 10'($urandom_range(0, h_fit));
				left = 10'($urandom_range(0, w_fit));
			end
			default: begin
				cw = 11'($urandom_range(1, w_fit));
				chh = 11'($urandom_range(1, h_fit));
				top = 10'($urandom_range(0, h_fit - chh));
				left = 10'($urandom_range(0, w_fit - cw));
			end
		endcase
		drain();
		load_config(w_reg, h_reg, cw, chh, {top, left}, 1'($urandom_range(0, 1)),
			pick_scale(), pick_means());
		full = w_fit * h_fit * CHANNELS;
		images = $urandom_range(1, 3);
		repeat (images) begin
			n = full;
			if (n > IMAGE_CAP) n = $urandom_range(30, IMAGE_CAP);
			else if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
			send_image(n, $urandom_range(0, 6) != 0, 1'b1);
			rand_bytes += n;
		end
	endtask

	initial begin
		board = new();
		arst_n <= 1'b0;
		pix_valid <= 1'b0;
		pixel <= '0;
		start_req <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		calm = 1'b0;
		hold_req = 1'b0;
		rand_bytes = 0;
		phase_count = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// settings after reset: full 1024x1024 image, unit scale, zero means
		send_byte(8'd0, 1'b1);
		send_byte(8'd255, 1'b0);
		send_byte(8'd128, 1'b0);
		drain();

		// 2x2 image, mirrored, extreme means and the largest scale
		load_config(11'd2, 11'd2, 11'd0, 11'd0, 20'd0, 1'b1, 18'h3FFFF, 48'h0001_8000_FFFF);
		for (int i = 0; i < 12; i++) send_byte((i % 2) ? 8'd255 : 8'd0, i == 0);
		// counters wrap to the next image without a start flag
		send_byte(8'd255, 1'b0);
		drain();

		// zero image size clamps to 1; oversized crop clamps to 1024 (top of dest_index)
		load_config(11'd0, 11'd0, 11'h7FF, 11'd1024, 20'd0, 1'b1, 18'd65536,
			48'hFFFF_0000_1234);
		for (int i = 0; i < 6; i++) send_byte(rand_pixel(), i == 0);
		drain();

		// window entirely beyond the image: nothing comes out
		load_config(11'd3, 11'd3, 11'd2, 11'd2, {10'd1023, 10'd1023}, 1'b0, pick_scale(),
			pick_means());
		for (int i = 0; i < 3; i++) send_byte(rand_pixel(), i == 0);

		// random phases; a few fixed ones for the long hold-off and the largest sizes
		while (rand_bytes < RAND_ITEMS) begin
			phase_count++;
			calm = (rand_bytes + TAIL_ITEMS >= RAND_ITEMS) || ($urandom_range(0, 3) == 0);
			case (phase_count)
				2: begin
					// output held off while input keeps coming, so the block backs up
					drain();
					load_config(11'd6, 11'd4, 11'd0, 11'd0, 20'd0, 1'($urandom_range(0, 1)),
						pick_scale(), pick_means());
					hold_req = 1'b1;
					send_image(72, 1'b1, 1'b0);
					rand_bytes += 72;
				end
				3: begin
					// start of a full-width row, window a few columns in
					drain();
					load_config(11'd1024, 11'd1, 11'd24, 11'd1, {10'd0, 10'd8}, 1'b1,
						pick_scale(), pick_means());
					send_image(3 * 40, 1'b1, 1'b0);
					rand_bytes += 3 * 40;
				end
				5: begin
					// top of a full-height column, window a few rows down
					drain();
					load_config(11'd1, 11'd1024, 11'd1, 11'd24, {10'd8, 10'd0}, 1'b0,
						pick_scale(), pick_means());
					send_image(3 * 40, 1'b1, 1'b0);
					rand_bytes += 3 * 40;
				end
				default: random_phase();
			endcase
		end

		drain();
		$display("Run covered %0d input bytes over %0d random phases, %0d results checked.",
			board.bytes_taken, phase_count, board.results_checked);
		$display("Crop on/off and off-image windows, mirror, wrap, clamps, wide row/tall column.");
		if (board.errors == 0) $display("*** PASSED ***");
		else $display("*** FAILED ***");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/cmms_pkg.sv
hw/rtl/cmms_regs.sv
hw/rtl/cmms_seq.sv
hw/rtl/cmms_proc.sv
hw/rtl/crop_mirror_mean_scale_pixel.sv
dv/crop_mirror_mean_scale_pixel_tb.sv
